[rtl/skm_pkg.sv]
`timescale 1ns / 1ps
// skm_pkg: shared types and constants for the stepper keyframe sequencer
// no dependencies; used by the interfaces, the divider and the top level
package skm_pkg;

    // axis states, numbered in sequencer order
    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_CAL_UP   = 3'd1,
        MODE_CAL_HIT  = 3'd2,
        MODE_CAL_DONE = 3'd3,
        MODE_ACTIVE   = 3'd4,
        MODE_PAST     = 3'd5,
        MODE_HIT      = 3'd6,
        MODE_WAIT     = 3'd7
    } t_mode;

    // input word opcodes
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_START_ANI = 2'd1,
        OP_START_CAL = 2'd2,
        OP_KEYFRAME  = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [2:0] CFG_REVERSE   = 3'd0;
    localparam logic [2:0] CFG_MAX_SPEED = 3'd1;
    localparam logic [2:0] CFG_CAL_SPEED = 3'd2;
    localparam logic [2:0] CFG_BACKOFF   = 3'd3;
    localparam logic [2:0] CFG_SETTLE    = 3'd4;
    localparam logic [2:0] CFG_OVERSHOOT = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // speed divider widths: 1000 * 33-bit difference, 32-bit time difference
    localparam int NUM_W = 43;
    localparam int DEN_W = 32;
    localparam int Q_W   = 12;   // saturated quotient, wide enough for +-2047
    localparam int CNT_W = 6;

    localparam logic signed [43:0] SPEED_SCALE = 44'sd1000;

endpackage

[rtl/skm_if.sv]
`timescale 1ns / 1ps
// skm_if: valid/ready channel interfaces for items, results and configuration
// depends on skm_pkg for the field widths
interface skm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [30:0]        elapsed_ms;
    logic               endstop_pressed;
    logic signed [31:0] motor_position;
    logic signed [31:0] key_target;
    logic [30:0]        key_time_ms;
    modport source (output valid, op, elapsed_ms, endstop_pressed, motor_position,
                    key_target, key_time_ms, input ready);
    modport sink (input valid, op, elapsed_ms, endstop_pressed, motor_position,
                  key_target, key_time_ms, output ready);
endinterface

interface skm_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         axis_state;
    logic signed [10:0] speed_command;
    logic               speed_set;
    logic               zero_position;
    logic               run_step;
    modport source (output valid, axis_state, speed_command, speed_set, zero_position,
                    run_step, input ready);
    modport sink (input valid, axis_state, speed_command, speed_set, zero_position,
                  run_step, output ready);
endinterface

interface skm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [skm_pkg::CFG_IDX_W-1:0]  index;
    logic [skm_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/skm_div.sv]
`timescale 1ns / 1ps
// skm_div: bit-serial restoring signed divider, one quotient bit per cycle
// depends on skm_pkg; quotient truncates toward zero and saturates to Q_W bits
module skm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [skm_pkg::NUM_W-1:0] i_num,
    input  logic signed [skm_pkg::DEN_W-1:0] i_den,
    output logic                             o_done,
    output logic signed [skm_pkg::Q_W-1:0]   o_quot
);
    import skm_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;
    logic             r_done;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_trial;
    logic             w_fit;
    logic [Q_W-2:0]   w_mag;

    // one restoring step
    always_comb begin
        w_shift = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        w_trial = w_shift - {1'b0, r_den};
        w_fit   = (w_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
                r_rem  <= '0;
                r_quo  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : i_num;
                r_den  <= i_den[DEN_W-1] ? DEN_W'(-i_den) : i_den;
                r_neg  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            end else if (r_busy) begin
                r_rem <= w_fit ? w_trial : w_shift;
                r_quo <= {r_quo[NUM_W-2:0], w_fit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // saturate magnitude and apply sign
    always_comb begin
        if (r_quo[NUM_W-1:Q_W-1] != '0) w_mag = '1;
        else                            w_mag = r_quo[Q_W-2:0];
        o_quot = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end

    assign o_done = r_done;

endmodule

[rtl/stepper_keyframe_motion_fsm.sv]
`timescale 1ns / 1ps
// stepper_keyframe_motion_fsm: eight-state stepper axis sequencer, top level
// depends on skm_pkg, skm_if and skm_div
//
// One word in, one result word out. A start command or a keyframe loads its result
// into the output register at the accepting edge. A tick passes through S_PRE,
// which registers the divider-free transitions and the 1000 x position-difference
// numerator; S_LOAD, which loads the divider; S_DIV, which runs the bit-serial speed
// divider until its registered done flag; and S_FIN, which makes the final state
// update. The divider's one-bit-per-cycle loop sets the length of a tick.
// The input is not ready again until the result word has been taken.
// Configuration writes are always accepted and must only be issued while idle.
module stepper_keyframe_motion_fsm (
    input  logic   i_clk,
    input  logic   i_rst_n,
    skm_in_if.sink   i_in,
    skm_out_if.source o_out,
    skm_cfg_if.sink  i_cfg
);
    import skm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PRE, S_LOAD, S_DIV, S_FIN, S_OUT} t_seq;

    t_seq               r_seq;
    // configuration
    logic               r_rev;
    logic [9:0]         r_max;
    logic signed [10:0] r_cal;
    logic signed [10:0] r_back;
    logic [15:0]        r_settle;
    logic [15:0]        r_over;
    // axis state
    t_mode              r_cur;
    t_mode              r_pend;
    logic signed [10:0] r_held;
    logic signed [31:0] r_gpos;
    logic [30:0]        r_gtime;
    logic               r_fresh;
    logic [30:0]        r_hit;
    logic [30:0]        r_now;
    // tick scratch
    logic               r_endstop;
    logic signed [31:0] r_pos;
    logic               r_zero;
    logic signed [NUM_W-1:0] r_num;
    logic signed [DEN_W-1:0] r_den;
    logic               r_dtz;
    // result register
    logic               r_o_valid;
    logic [2:0]         r_o_state;
    logic signed [10:0] r_o_cmd;
    logic               r_o_set;
    logic               r_o_zero;
    logic               r_o_run;

    logic               w_div_done;
    logic signed [Q_W-1:0] w_div_q;

    // pre-transition signals
    logic signed [32:0] w_since;
    logic               w_settled;
    t_mode              n_pend;
    logic               n_fresh_pre;
    logic               n_zero;
    logic signed [31:0] w_pos_div;
    logic signed [32:0] w_diff;
    logic signed [43:0] w_prod;

    // finish signals
    logic signed [Q_W-1:0] w_q;
    t_mode              n_mode;
    logic               w_changed;
    logic               w_fresh_mid;
    logic               w_upd;
    logic signed [Q_W-1:0] w_s;
    logic signed [Q_W-1:0] w_mx;
    logic signed [Q_W-1:0] w_clamp;
    logic               w_set;
    logic               w_run;
    logic               w_hit_now;
    logic               w_hit_clr;
    logic signed [10:0] w_cmd;

    skm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_seq == S_LOAD),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // transitions that need no speed, plus zeroing and the speed numerator
    always_comb begin
        w_since     = $signed({2'b00, r_now}) - $signed({2'b00, r_hit});
        w_settled   = (w_since > $signed({17'd0, r_settle})) && !r_endstop;
        n_pend      = r_pend;
        n_fresh_pre = r_fresh;
        if (r_pend == r_cur) begin
            case (r_cur)
                MODE_CAL_UP:  if (r_endstop) n_pend = MODE_CAL_HIT;
                MODE_CAL_HIT: if (w_settled) n_pend = MODE_CAL_DONE;
                MODE_ACTIVE: begin
                    if (r_endstop) n_pend = MODE_HIT;
                    else if ({1'b0, r_now} >= ({1'b0, r_gtime} + {16'd0, r_over}))
                        n_pend = MODE_PAST;
                end
                MODE_PAST: if (r_fresh) begin
                    n_fresh_pre = 1'b0;
                    n_pend      = MODE_ACTIVE;
                end
                MODE_HIT:     if (w_settled) n_pend = MODE_WAIT;
                default: ;
            endcase
        end
        n_zero    = (n_pend != r_cur) && ((r_cur == MODE_CAL_HIT) || (r_cur == MODE_HIT));
        w_pos_div = n_zero ? 32'sd0 : r_pos;
        w_diff    = $signed({r_gpos[31], r_gpos}) - $signed({w_pos_div[31], w_pos_div});
        w_prod    = $signed({{11{w_diff[32]}}, w_diff}) * SPEED_SCALE;
    end

    // final transition and speed update
    always_comb begin
        w_q         = r_dtz ? '0 : w_div_q;
        n_mode      = r_pend;
        w_fresh_mid = r_fresh;
        if ((r_pend == r_cur) && (r_cur == MODE_WAIT) && r_fresh && (w_q > 0)) begin
            n_mode      = MODE_ACTIVE;
            w_fresh_mid = 1'b0;
        end
        w_changed = (n_mode != r_cur);
        w_upd     = 1'b0;
        w_s       = '0;
        w_run     = 1'b0;
        w_hit_now = 1'b0;
        w_hit_clr = 1'b0;
        case (n_mode)
            MODE_CAL_UP: begin
                w_upd = w_changed;
                w_s   = Q_W'(r_cal);
                w_run = 1'b1;
            end
            MODE_CAL_HIT, MODE_HIT: begin
                w_upd     = w_changed;
                w_s       = Q_W'(r_back);
                w_hit_now = w_changed;
                w_run     = 1'b1;
            end
            MODE_CAL_DONE, MODE_PAST: begin
                w_upd = w_changed;
                w_run = w_changed;
            end
            MODE_ACTIVE: begin
                w_upd = w_changed || w_fresh_mid;
                w_s   = w_q;
                w_run = 1'b1;
            end
            MODE_WAIT: begin
                w_upd     = w_changed;
                w_run     = w_changed;
                w_hit_clr = w_changed;
            end
            default: ;
        endcase
        w_mx = $signed({2'b00, r_max});
        if (w_s > w_mx)       w_clamp = w_mx;
        else if (w_s < -w_mx) w_clamp = -w_mx;
        else                  w_clamp = w_s;
        w_set = w_upd && (w_s != Q_W'(r_held));
        if (w_clamp == '0) w_cmd = 11'sd1;
        else if (r_rev)    w_cmd = 11'(-w_clamp);
        else               w_cmd = 11'(w_clamp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= S_IDLE;
            r_rev     <= 1'b0;
            r_max     <= 10'd200;
            r_cal     <= -11'sd200;
            r_back    <= 11'sd60;
            r_settle  <= 16'd300;
            r_over    <= 16'd100;
            r_cur     <= MODE_INIT;
            r_pend    <= MODE_INIT;
            r_held    <= '0;
            r_gpos    <= '0;
            r_gtime   <= '0;
            r_fresh   <= 1'b0;
            r_hit     <= '0;
            r_now     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_REVERSE:   r_rev    <= i_cfg.data[0];
                    CFG_MAX_SPEED: r_max    <= i_cfg.data[9:0];
                    CFG_CAL_SPEED: r_cal    <= i_cfg.data[10:0];
                    CFG_BACKOFF:   r_back   <= i_cfg.data[10:0];
                    CFG_SETTLE:    r_settle <= i_cfg.data;
                    CFG_OVERSHOOT: r_over   <= i_cfg.data;
                    default: ;
                endcase
            end
            case (r_seq)
                S_IDLE: if (i_in.valid) begin
                    r_o_state <= r_cur;
                    r_o_cmd   <= '0;
                    r_o_set   <= 1'b0;
                    r_o_zero  <= 1'b0;
                    r_o_run   <= 1'b0;
                    case (t_op'(i_in.op))
                        OP_START_ANI: begin
                            r_pend    <= MODE_ACTIVE;
                            r_o_valid <= 1'b1;
                            r_seq     <= S_OUT;
                        end
                        OP_START_CAL: begin
                            r_pend    <= MODE_CAL_UP;
                            r_o_valid <= 1'b1;
                            r_seq     <= S_OUT;
                        end
                        OP_KEYFRAME: begin
                            r_gpos    <= i_in.key_target;
                            r_gtime   <= i_in.key_time_ms;
                            r_fresh   <= 1'b1;
                            r_o_valid <= 1'b1;
                            r_seq     <= S_OUT;
                        end
                        default: begin
                            r_now     <= i_in.elapsed_ms;
                            r_endstop <= i_in.endstop_pressed;
                            r_pos     <= r_rev ? -i_in.motor_position : i_in.motor_position;
                            r_seq     <= S_PRE;
                        end
                    endcase
                end
                // settle the divider-free transitions, build the quotient operands
                S_PRE: begin
                    r_pend  <= n_pend;
                    r_fresh <= n_fresh_pre;
                    r_zero  <= n_zero;
                    r_num   <= w_prod[NUM_W-1:0];
                    r_den   <= $signed({1'b0, r_gtime}) - $signed({1'b0, r_now});
                    r_dtz   <= (r_gtime == r_now);
                    r_seq   <= S_LOAD;
                end
                S_LOAD: r_seq <= S_DIV;
                S_DIV:  if (w_div_done) r_seq <= S_FIN;
                // commit the new mode and the speed word
                S_FIN: begin
                    r_cur     <= n_mode;
                    r_pend    <= n_mode;
                    r_fresh   <= w_upd ? 1'b0 : w_fresh_mid;
                    if (w_set)     r_held <= 11'(w_clamp);
                    if (w_hit_now) r_hit  <= r_now;
                    if (w_hit_clr) r_hit  <= '0;
                    r_o_state <= n_mode;
                    r_o_cmd   <= w_set ? w_cmd : 11'sd0;
                    r_o_set   <= w_set;
                    r_o_zero  <= r_zero;
                    r_o_run   <= w_run;
                    r_o_valid <= 1'b1;
                    r_seq     <= S_OUT;
                end
                S_OUT: if (o_out.ready) begin
                    r_o_valid <= 1'b0;
                    r_seq     <= S_IDLE;
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

    // ports
    assign i_in.ready          = (r_seq == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_o_valid;
    assign o_out.axis_state    = r_o_state;
    assign o_out.speed_command = r_o_cmd;
    assign o_out.speed_set     = r_o_set;
    assign o_out.zero_position = r_o_zero;
    assign o_out.run_step      = r_o_run;

endmodule
